>>> src/cptri_pkg.sv
// Shared widths, region codes, payload types and helpers for the closest-point-on-triangle core.
`timescale 1ns / 1ps

package cptri_pkg;

    // Coordinate and intermediate widths
    localparam int COORD_W   = 32;
    localparam int DIFF_W    = COORD_W + 1;     // vertex differences
    localparam int DOT_W     = 68;              // dot products and their differences
    localparam int V_W       = 136;             // region determinants and face denominator
    localparam int NUM_W     = 168;             // interpolation numerators
    localparam int AXES      = 3;
    localparam int NUM_DOTS  = 6;
    localparam int NUM_DETS  = 6;

    // Stream widths
    localparam int IN_FIELDS = 12;
    localparam int S_TDATA_W = IN_FIELDS * COORD_W;
    localparam int REGION_W  = 3;
    localparam int M_FIELD_W = AXES * COORD_W + REGION_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    // Multiplier: signed MUL_A_W x MUL_B_W, cut into 32x32 limb products
    localparam int LIMB_W      = 32;
    localparam int MUL_A_W     = DOT_W;
    localparam int MUL_B_W     = V_W;
    localparam int MUL_P_W     = NUM_W;
    localparam int MUL_A_LIMBS = (MUL_A_W + LIMB_W - 1) / LIMB_W;
    localparam int MUL_B_LIMBS = (MUL_B_W + LIMB_W - 1) / LIMB_W;
    localparam int MUL_LAT     = 5;

    // Divider: rounded quotient, magnitude clamped at 2^DIV_QBITS
    localparam int DIV_QBITS = COORD_W + 2;
    localparam int DIV_N_W   = NUM_W + 1;
    localparam int DIV_D_W   = V_W + 1;
    localparam int DIV_R_W   = DIV_D_W + DIV_QBITS;
    localparam int DIV_SUM_W = DIV_QBITS + 3;
    localparam int DIV_LAT   = DIV_QBITS + 3;

    // Register stages from input to output; the first is loaded by the accepting edge
    localparam int TOTAL_LAT = 1 + MUL_LAT + 1 + MUL_LAT + 1 + 1 + MUL_LAT + 1 + DIV_LAT;

    // Region codes
    localparam logic [REGION_W-1:0] REGION_VERT_A = 3'd0;
    localparam logic [REGION_W-1:0] REGION_VERT_B = 3'd1;
    localparam logic [REGION_W-1:0] REGION_EDGE_AB = 3'd2;
    localparam logic [REGION_W-1:0] REGION_VERT_C = 3'd3;
    localparam logic [REGION_W-1:0] REGION_EDGE_AC = 3'd4;
    localparam logic [REGION_W-1:0] REGION_EDGE_BC = 3'd5;
    localparam logic [REGION_W-1:0] REGION_FACE = 3'd6;

    typedef logic [AXES-1:0][COORD_W-1:0] coord3_t;
    typedef logic [AXES-1:0][DIFF_W-1:0]  diff3_t;
    typedef logic [NUM_DOTS-1:0][DOT_W-1:0] dots_t;

    // Triangle data carried along the front of the pipe
    typedef struct packed {
        coord3_t a;
        coord3_t b;
        coord3_t c;
        diff3_t  ab;
        diff3_t  ac;
        diff3_t  bc;
    } geo_t;

    // Operands picked for the interpolation step
    typedef struct packed {
        logic [REGION_W-1:0] region;
        coord3_t             base;
        diff3_t              u;
        diff3_t              v;
        logic [V_W-1:0]      nu;
        logic [V_W-1:0]      nv;
        logic [V_W-1:0]      den;
    } sel_t;

    function automatic logic [DIFF_W-1:0] coord_diff(input logic [COORD_W-1:0] x,
                                                     input logic [COORD_W-1:0] y);
        return {x[COORD_W-1], x} - {y[COORD_W-1], y};
    endfunction

    function automatic logic [MUL_A_W-1:0] diff_to_a(input logic [DIFF_W-1:0] x);
        return {{(MUL_A_W - DIFF_W){x[DIFF_W-1]}}, x};
    endfunction

    function automatic logic [MUL_B_W-1:0] diff_to_b(input logic [DIFF_W-1:0] x);
        return {{(MUL_B_W - DIFF_W){x[DIFF_W-1]}}, x};
    endfunction

    function automatic logic [V_W-1:0] dot_to_v(input logic [DOT_W-1:0] x);
        return {{(V_W - DOT_W){x[DOT_W-1]}}, x};
    endfunction

    function automatic logic dot_le0(input logic [DOT_W-1:0] x);
        return x[DOT_W-1] || (x == '0);
    endfunction

    function automatic logic v_le0(input logic [V_W-1:0] x);
        return x[V_W-1] || (x == '0);
    endfunction

endpackage

>>> src/cptri_mul.sv
// Pipelined signed wide multiplier built from 32x32 limb products.
`timescale 1ns / 1ps

module cptri_mul (
    input  logic                           aclk,
    input  logic                           en,
    input  logic [cptri_pkg::MUL_A_W-1:0]  a,
    input  logic [cptri_pkg::MUL_B_W-1:0]  b,
    output logic [cptri_pkg::MUL_P_W-1:0]  p
);
    localparam int AW = cptri_pkg::MUL_A_LIMBS * cptri_pkg::LIMB_W;
    localparam int BW = cptri_pkg::MUL_B_LIMBS * cptri_pkg::LIMB_W;
    localparam int LW = cptri_pkg::LIMB_W;
    localparam int PW = cptri_pkg::MUL_P_W;

    logic [cptri_pkg::MUL_A_W-1:0] a_abs;
    logic [cptri_pkg::MUL_B_W-1:0] b_abs;
    logic [AW-1:0]                 amag_reg;
    logic [BW-1:0]                 bmag_reg;
    logic [3:0]                    neg_reg;
    logic [2*LW-1:0]               pp_reg [cptri_pkg::MUL_A_LIMBS][cptri_pkg::MUL_B_LIMBS];
    logic [PW-1:0]                 row_next [cptri_pkg::MUL_A_LIMBS];
    logic [PW-1:0]                 row_reg [cptri_pkg::MUL_A_LIMBS];
    logic [PW-1:0]                 mag_next;
    logic [PW-1:0]                 mag_reg;
    logic [PW-1:0]                 p_reg;

    // Magnitudes of the operands
    assign a_abs = a[cptri_pkg::MUL_A_W-1] ? (~a + 1'b1) : a;
    assign b_abs = b[cptri_pkg::MUL_B_W-1] ? (~b + 1'b1) : b;

    // Row sums of the limb products, then the sum of rows
    always_comb begin
        for (int i = 0; i < cptri_pkg::MUL_A_LIMBS; i++) begin
            row_next[i] = '0;
            for (int j = 0; j < cptri_pkg::MUL_B_LIMBS; j++) begin
                row_next[i] = row_next[i] + (PW'(pp_reg[i][j]) << (LW * j));
            end
        end
        mag_next = '0;
        for (int i = 0; i < cptri_pkg::MUL_A_LIMBS; i++) begin
            mag_next = mag_next + (row_reg[i] << (LW * i));
        end
    end

    // Five stages: magnitude, limb products, rows, total, sign
    always_ff @(posedge aclk) begin
        if (en) begin
            amag_reg <= AW'(a_abs);
            bmag_reg <= BW'(b_abs);
            neg_reg  <= {neg_reg[2:0], a[cptri_pkg::MUL_A_W-1] ^ b[cptri_pkg::MUL_B_W-1]};
            for (int i = 0; i < cptri_pkg::MUL_A_LIMBS; i++) begin
                for (int j = 0; j < cptri_pkg::MUL_B_LIMBS; j++) begin
                    pp_reg[i][j] <= amag_reg[i*LW +: LW] * bmag_reg[j*LW +: LW];
                end
            end
            row_reg <= row_next;
            mag_reg <= mag_next;
            p_reg   <= neg_reg[3] ? (~mag_reg + 1'b1) : mag_reg;
        end
    end

    assign p = p_reg;

endmodule

>>> src/cptri_div.sv
// Pipelined rounding divider that adds the quotient to a base coordinate and saturates.
`timescale 1ns / 1ps

module cptri_div (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [cptri_pkg::NUM_W-1:0]   num,
    input  logic [cptri_pkg::V_W-1:0]     den,
    input  logic [cptri_pkg::COORD_W-1:0] base,
    output logic [cptri_pkg::COORD_W-1:0] coord
);
    localparam int QB = cptri_pkg::DIV_QBITS;
    localparam int RW = cptri_pkg::DIV_R_W;
    localparam int DW = cptri_pkg::DIV_D_W;
    localparam int SW = cptri_pkg::DIV_SUM_W;
    localparam int CW = cptri_pkg::COORD_W;

    typedef struct packed {
        logic          sign;
        logic          zero;
        logic          ovf;
        logic [CW-1:0] base;
    } div_ctl_t;

    logic [cptri_pkg::NUM_W-1:0]   an;
    logic [cptri_pkg::V_W-1:0]     ad;
    logic [cptri_pkg::DIV_N_W-1:0] pn_reg;
    logic [DW-1:0]                 pd_reg;
    div_ctl_t                      pctl_reg;
    logic [RW-1:0]                 r_reg [QB+1];
    logic [DW-1:0]                 d_reg [QB+1];
    logic [QB-1:0]                 q_reg [QB+1];
    div_ctl_t                      ctl_reg [QB+1];
    logic [QB:0]                   qmag;
    logic [QB+1:0]                 qsgn;
    logic [SW-1:0]                 sum;
    logic [CW-1:0]                 coord_reg;

    assign an = num[cptri_pkg::NUM_W-1] ? (~num + 1'b1) : num;
    assign ad = den[cptri_pkg::V_W-1] ? (~den + 1'b1) : den;

    // Prep: N = 2|num| + |den|, D = 2|den|, then the clamp test N >= D * 2^QB
    always_ff @(posedge aclk) begin
        if (en) begin
            pn_reg        <= {an, 1'b0} + cptri_pkg::DIV_N_W'(ad);
            pd_reg        <= {ad, 1'b0};
            pctl_reg.sign <= num[cptri_pkg::NUM_W-1] ^ den[cptri_pkg::V_W-1];
            pctl_reg.zero <= (den == '0);
            pctl_reg.ovf  <= 1'b0;
            pctl_reg.base <= base;

            r_reg[0]   <= RW'(pn_reg);
            d_reg[0]   <= pd_reg;
            q_reg[0]   <= '0;
            ctl_reg[0] <= '{sign: pctl_reg.sign, zero: pctl_reg.zero,
                            ovf: (RW'(pn_reg) >= {pd_reg, {QB{1'b0}}}),
                            base: pctl_reg.base};
        end
    end

    // One restoring step per stage, most significant quotient bit first
    for (genvar s = 0; s < QB; s++) begin : g_step
        logic [RW-1:0] trial;
        logic          take;
        assign trial = RW'(d_reg[s]) << (QB - 1 - s);
        assign take  = r_reg[s] >= trial;
        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[s+1]   <= take ? (r_reg[s] - trial) : r_reg[s];
                d_reg[s+1]   <= d_reg[s];
                q_reg[s+1]   <= {q_reg[s][QB-2:0], take};
                ctl_reg[s+1] <= ctl_reg[s];
            end
        end
    end

    // Sign, base add and saturation
    always_comb begin
        if (ctl_reg[QB].zero) begin
            qmag = '0;
        end else if (ctl_reg[QB].ovf) begin
            qmag = {1'b1, {QB{1'b0}}};
        end else begin
            qmag = {1'b0, q_reg[QB]};
        end
        qsgn = ctl_reg[QB].sign ? (~{1'b0, qmag} + 1'b1) : {1'b0, qmag};
        sum  = {{(SW - CW){ctl_reg[QB].base[CW-1]}}, ctl_reg[QB].base} + {qsgn[QB+1], qsgn};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (sum[SW-1:CW-1] == '0 || sum[SW-1:CW-1] == '1) begin
                coord_reg <= sum[CW-1:0];
            end else begin
                coord_reg <= sum[SW-1] ? {1'b1, {(CW - 1){1'b0}}} : {1'b0, {(CW - 1){1'b1}}};
            end
        end
    end

    assign coord = coord_reg;

endmodule

>>> src/closest_point_on_triangle_core.sv
// Top level: closest point on a 3D triangle, fully pipelined.
//
// Usage:
//   Input stream (s_*): one transfer carries a query point p and vertices a, b, c,
//   twelve signed Q16.16 coordinates. Output stream (m_*): one transfer per input
//   carries the closest point on the triangle (saturated Q16.16) and a region code
//   (vertex a/b/c, edge ab/ac/bc or face).
//   Throughput: one transfer per cycle, sustained unless the output stalls.
//   Pipeline: 57 register stages from input to output (the first loaded by the
//   accepting edge): an input stage, 18 dot-product multipliers, the dot sums,
//   6 determinant multipliers, the determinant differences, region select, 6
//   interpolation multipliers (each multiplier 5 stages of 32x32 limb products),
//   the numerator sums and a 37-stage divider per axis (prep, clamp test, 34
//   restoring steps of one quotient bit, saturation).
//   Reset: aresetn (synchronous, active low) clears all valid bits; the pipe is
//   empty and ready in the next cycle.
//   Stall: when m_tvalid is high and m_tready low, the whole pipe holds and
//   s_tready drops; nothing is lost or repeated. s_tready is high whenever the
//   output register is empty or being taken.
`timescale 1ns / 1ps

module closest_point_on_triangle_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    // query_x, query_y, query_z, vert_a_x..z, vert_b_x..z, vert_c_x..z (32 bits each)
    input  logic [cptri_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // closest_x, closest_y, closest_z (32 bits each), region (3 bits), zero fill
    output logic [cptri_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready
);
    localparam int CW = cptri_pkg::COORD_W;
    localparam int ML = cptri_pkg::MUL_LAT;
    localparam int DL = cptri_pkg::DIV_LAT;

    logic                           en;
    logic [cptri_pkg::TOTAL_LAT-1:0] vld_reg;

    cptri_pkg::coord3_t p_in, a_in, b_in, c_in;
    cptri_pkg::geo_t    s1_geo_reg;
    cptri_pkg::diff3_t  s1_ap_reg, s1_bp_reg, s1_cp_reg;

    logic [cptri_pkg::NUM_DOTS-1:0][cptri_pkg::AXES-1:0][cptri_pkg::DIFF_W-1:0] dot_x, dot_y;
    logic [cptri_pkg::MUL_P_W-1:0] dot_p [cptri_pkg::NUM_DOTS][cptri_pkg::AXES];
    cptri_pkg::geo_t               geo1_dly_reg [ML];
    cptri_pkg::dots_t              dots_next;
    cptri_pkg::dots_t              dots_reg;
    cptri_pkg::geo_t               geo2_reg;

    logic [cptri_pkg::NUM_DETS-1:0][cptri_pkg::DOT_W-1:0] det_x, det_y;
    logic [cptri_pkg::MUL_P_W-1:0] det_p [cptri_pkg::NUM_DETS];
    cptri_pkg::geo_t               geo2_dly_reg [ML];
    cptri_pkg::dots_t              dots_dly_reg [ML];
    cptri_pkg::geo_t               geo3_reg;
    cptri_pkg::dots_t              dots3_reg;
    logic [cptri_pkg::V_W-1:0]     va_reg, vb_reg, vc_reg;

    logic [cptri_pkg::DOT_W-1:0]   e43, e56, d1m3, d2m6;
    logic [cptri_pkg::REGION_W-1:0] region;
    cptri_pkg::sel_t               sel_next;
    cptri_pkg::sel_t               sel_reg;

    logic [cptri_pkg::MUL_P_W-1:0] pu [cptri_pkg::AXES];
    logic [cptri_pkg::MUL_P_W-1:0] pv [cptri_pkg::AXES];
    cptri_pkg::sel_t               sel_dly_reg [ML];
    logic [cptri_pkg::NUM_W-1:0]   num_reg [cptri_pkg::AXES];
    logic [cptri_pkg::V_W-1:0]     den_reg;
    cptri_pkg::coord3_t            base_reg;
    logic [cptri_pkg::REGION_W-1:0] region_dly_reg [DL+1];
    logic [CW-1:0]                 coord [cptri_pkg::AXES];

    // Global advance: the whole pipe moves unless the output is held
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[cptri_pkg::TOTAL_LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[cptri_pkg::TOTAL_LAT-2:0], s_tvalid};
        end
    end

    // Input unpack and vertex differences
    always_comb begin
        for (int i = 0; i < cptri_pkg::AXES; i++) begin
            p_in[i] = s_tdata[(i) * CW +: CW];
            a_in[i] = s_tdata[(3 + i) * CW +: CW];
            b_in[i] = s_tdata[(6 + i) * CW +: CW];
            c_in[i] = s_tdata[(9 + i) * CW +: CW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_geo_reg.a <= a_in;
            s1_geo_reg.b <= b_in;
            s1_geo_reg.c <= c_in;
            for (int i = 0; i < cptri_pkg::AXES; i++) begin
                s1_geo_reg.ab[i] <= cptri_pkg::coord_diff(b_in[i], a_in[i]);
                s1_geo_reg.ac[i] <= cptri_pkg::coord_diff(c_in[i], a_in[i]);
                s1_geo_reg.bc[i] <= cptri_pkg::coord_diff(c_in[i], b_in[i]);
                s1_ap_reg[i]     <= cptri_pkg::coord_diff(p_in[i], a_in[i]);
                s1_bp_reg[i]     <= cptri_pkg::coord_diff(p_in[i], b_in[i]);
                s1_cp_reg[i]     <= cptri_pkg::coord_diff(p_in[i], c_in[i]);
            end
        end
    end

    // Dot products d1..d6: ab.ap, ac.ap, ab.bp, ac.bp, ab.cp, ac.cp
    assign dot_x[0] = s1_geo_reg.ab;
    assign dot_x[1] = s1_geo_reg.ac;
    assign dot_x[2] = s1_geo_reg.ab;
    assign dot_x[3] = s1_geo_reg.ac;
    assign dot_x[4] = s1_geo_reg.ab;
    assign dot_x[5] = s1_geo_reg.ac;
    assign dot_y[0] = s1_ap_reg;
    assign dot_y[1] = s1_ap_reg;
    assign dot_y[2] = s1_bp_reg;
    assign dot_y[3] = s1_bp_reg;
    assign dot_y[4] = s1_cp_reg;
    assign dot_y[5] = s1_cp_reg;

    for (genvar k = 0; k < cptri_pkg::NUM_DOTS; k++) begin : g_dot
        for (genvar i = 0; i < cptri_pkg::AXES; i++) begin : g_axis
            cptri_mul u_mul (
                .aclk (aclk),
                .en   (en),
                .a    (cptri_pkg::diff_to_a(dot_x[k][i])),
                .b    (cptri_pkg::diff_to_b(dot_y[k][i])),
                .p    (dot_p[k][i])
            );
        end
    end

    always_comb begin
        for (int k = 0; k < cptri_pkg::NUM_DOTS; k++) begin
            dots_next[k] = dot_p[k][0][cptri_pkg::DOT_W-1:0]
                         + dot_p[k][1][cptri_pkg::DOT_W-1:0]
                         + dot_p[k][2][cptri_pkg::DOT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            geo1_dly_reg[0] <= s1_geo_reg;
            for (int k = 1; k < ML; k++) begin
                geo1_dly_reg[k] <= geo1_dly_reg[k-1];
            end
            dots_reg <= dots_next;
            geo2_reg <= geo1_dly_reg[ML-1];
        end
    end

    // Determinant products: d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4
    assign det_x[0] = dots_reg[0];
    assign det_y[0] = dots_reg[3];
    assign det_x[1] = dots_reg[2];
    assign det_y[1] = dots_reg[1];
    assign det_x[2] = dots_reg[4];
    assign det_y[2] = dots_reg[1];
    assign det_x[3] = dots_reg[0];
    assign det_y[3] = dots_reg[5];
    assign det_x[4] = dots_reg[2];
    assign det_y[4] = dots_reg[5];
    assign det_x[5] = dots_reg[4];
    assign det_y[5] = dots_reg[3];

    for (genvar k = 0; k < cptri_pkg::NUM_DETS; k++) begin : g_det
        cptri_mul u_mul (
            .aclk (aclk),
            .en   (en),
            .a    (det_x[k]),
            .b    (cptri_pkg::dot_to_v(det_y[k])),
            .p    (det_p[k])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            geo2_dly_reg[0]  <= geo2_reg;
            dots_dly_reg[0]  <= dots_reg;
            for (int k = 1; k < ML; k++) begin
                geo2_dly_reg[k] <= geo2_dly_reg[k-1];
                dots_dly_reg[k] <= dots_dly_reg[k-1];
            end
            geo3_reg  <= geo2_dly_reg[ML-1];
            dots3_reg <= dots_dly_reg[ML-1];
            vc_reg    <= det_p[0][cptri_pkg::V_W-1:0] - det_p[1][cptri_pkg::V_W-1:0];
            vb_reg    <= det_p[2][cptri_pkg::V_W-1:0] - det_p[3][cptri_pkg::V_W-1:0];
            va_reg    <= det_p[4][cptri_pkg::V_W-1:0] - det_p[5][cptri_pkg::V_W-1:0];
        end
    end

    // Region tests in priority order a, b, ab, c, ac, bc, face
    always_comb begin
        e43  = dots3_reg[3] - dots3_reg[2];
        e56  = dots3_reg[4] - dots3_reg[5];
        d1m3 = dots3_reg[0] - dots3_reg[2];
        d2m6 = dots3_reg[1] - dots3_reg[5];
        if (cptri_pkg::dot_le0(dots3_reg[0]) && cptri_pkg::dot_le0(dots3_reg[1])) begin
            region = cptri_pkg::REGION_VERT_A;
        end else if (!dots3_reg[2][cptri_pkg::DOT_W-1]
                     && cptri_pkg::dot_le0(dots3_reg[3] - dots3_reg[2])) begin
            region = cptri_pkg::REGION_VERT_B;
        end else if (cptri_pkg::v_le0(vc_reg) && !dots3_reg[0][cptri_pkg::DOT_W-1]
                     && cptri_pkg::dot_le0(dots3_reg[2])) begin
            region = cptri_pkg::REGION_EDGE_AB;
        end else if (!dots3_reg[5][cptri_pkg::DOT_W-1]
                     && cptri_pkg::dot_le0(dots3_reg[4] - dots3_reg[5])) begin
            region = cptri_pkg::REGION_VERT_C;
        end else if (cptri_pkg::v_le0(vb_reg) && !dots3_reg[1][cptri_pkg::DOT_W-1]
                     && cptri_pkg::dot_le0(dots3_reg[5])) begin
            region = cptri_pkg::REGION_EDGE_AC;
        end else if (cptri_pkg::v_le0(va_reg) && !e43[cptri_pkg::DOT_W-1]
                     && !e56[cptri_pkg::DOT_W-1]) begin
            region = cptri_pkg::REGION_EDGE_BC;
        end else begin
            region = cptri_pkg::REGION_FACE;
        end
    end

    // Operand select: base + (u * nu + v * nv) / den
    always_comb begin
        sel_next.region = region;
        sel_next.base   = geo3_reg.a;
        sel_next.u      = geo3_reg.ab;
        sel_next.v      = geo3_reg.ac;
        sel_next.nu     = '0;
        sel_next.nv     = '0;
        sel_next.den    = cptri_pkg::V_W'(1);
        unique case (region)
            cptri_pkg::REGION_VERT_A: begin
                sel_next.base = geo3_reg.a;
            end
            cptri_pkg::REGION_VERT_B: begin
                sel_next.base = geo3_reg.b;
            end
            cptri_pkg::REGION_VERT_C: begin
                sel_next.base = geo3_reg.c;
            end
            cptri_pkg::REGION_EDGE_AB: begin
                sel_next.nu  = cptri_pkg::dot_to_v(dots3_reg[0]);
                sel_next.den = cptri_pkg::dot_to_v(d1m3);
            end
            cptri_pkg::REGION_EDGE_AC: begin
                sel_next.nv  = cptri_pkg::dot_to_v(dots3_reg[1]);
                sel_next.den = cptri_pkg::dot_to_v(d2m6);
            end
            cptri_pkg::REGION_EDGE_BC: begin
                sel_next.base = geo3_reg.b;
                sel_next.u    = geo3_reg.bc;
                sel_next.nu   = cptri_pkg::dot_to_v(e43);
                sel_next.den  = cptri_pkg::dot_to_v(e43) + cptri_pkg::dot_to_v(e56);
            end
            cptri_pkg::REGION_FACE: begin
                sel_next.nu  = vb_reg;
                sel_next.nv  = vc_reg;
                sel_next.den = va_reg + vb_reg + vc_reg;
            end
            default: begin
                sel_next.base = geo3_reg.a;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sel_reg <= sel_next;
        end
    end

    // Interpolation numerators per axis
    for (genvar i = 0; i < cptri_pkg::AXES; i++) begin : g_emit
        cptri_mul u_mul_u (
            .aclk (aclk),
            .en   (en),
            .a    (cptri_pkg::diff_to_a(sel_reg.u[i])),
            .b    (sel_reg.nu),
            .p    (pu[i])
        );
        cptri_mul u_mul_v (
            .aclk (aclk),
            .en   (en),
            .a    (cptri_pkg::diff_to_a(sel_reg.v[i])),
            .b    (sel_reg.nv),
            .p    (pv[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sel_dly_reg[0] <= sel_reg;
            for (int k = 1; k < ML; k++) begin
                sel_dly_reg[k] <= sel_dly_reg[k-1];
            end
            for (int i = 0; i < cptri_pkg::AXES; i++) begin
                num_reg[i] <= pu[i] + pv[i];
            end
            den_reg           <= sel_dly_reg[ML-1].den;
            base_reg          <= sel_dly_reg[ML-1].base;
            region_dly_reg[0] <= sel_dly_reg[ML-1].region;
            for (int k = 1; k <= DL; k++) begin
                region_dly_reg[k] <= region_dly_reg[k-1];
            end
        end
    end

    // Rounded division, base add and saturation per axis
    for (genvar i = 0; i < cptri_pkg::AXES; i++) begin : g_div
        cptri_div u_div (
            .aclk  (aclk),
            .en    (en),
            .num   (num_reg[i]),
            .den   (den_reg),
            .base  (base_reg[i]),
            .coord (coord[i])
        );
    end

    // Result transfer
    assign m_tdata = {{(cptri_pkg::M_TDATA_W - cptri_pkg::M_FIELD_W){1'b0}},
                      region_dly_reg[DL], coord[2], coord[1], coord[0]};

endmodule

>>> tb/cptri_checker.sv
// Checker for the closest-point-on-triangle core: watches both streams, predicts and compares.
`timescale 1ns / 1ps

module cptri_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [cptri_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [cptri_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    output int                               err_count,
    output int                               pending
);
    localparam int CW = cptri_pkg::COORD_W;

    typedef logic signed [255:0] big_t;

    typedef struct packed {
        logic [cptri_pkg::REGION_W-1:0] region;
        logic signed [CW-1:0]           z;
        logic signed [CW-1:0]           y;
        logic signed [CW-1:0]           x;
    } point_res_t;

    point_res_t closest_q[$];

    function automatic big_t dot3(input big_t x0, x1, x2, y0, y1, y2);
        return x0 * y0 + x1 * y1 + x2 * y2;
    endfunction

    // quotient rounded half away from zero, zero on a zero denominator
    function automatic big_t div_round(input big_t num, input big_t den);
        big_t an, ad, q;
        if (den == 0) return 0;
        an = (num < 0) ? -num : num;
        ad = (den < 0) ? -den : den;
        q = (2 * an + ad) / (2 * ad);
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    function automatic logic signed [CW-1:0] sat_coord(input big_t v);
        big_t maxc, minc;
        maxc = (big_t'(1) <<< (CW - 1)) - 1;
        minc = -maxc - 1;
        if (v > maxc) return maxc[CW-1:0];
        if (v < minc) return minc[CW-1:0];
        return v[CW-1:0];
    endfunction

    // closest point: region tests in order a, b, ab, c, ac, bc, face
    function automatic point_res_t closest_point(input logic [cptri_pkg::S_TDATA_W-1:0] item);
        big_t p[3], a[3], b[3], c[3], ab[3], ac[3], bc[3], ap[3], bp[3], cp[3];
        big_t d1, d2, d3, d4, d5, d6, va, vb, vc, e43, e56;
        big_t base[3], u[3], v[3], nu, nv, den, r[3];
        logic [cptri_pkg::REGION_W-1:0] reg_code;
        point_res_t res;
        for (int i = 0; i < 3; i++) begin
            p[i] = $signed(item[CW*i +: CW]);
            a[i] = $signed(item[CW*(3+i) +: CW]);
            b[i] = $signed(item[CW*(6+i) +: CW]);
            c[i] = $signed(item[CW*(9+i) +: CW]);
            ab[i] = b[i] - a[i];
            ac[i] = c[i] - a[i];
            bc[i] = c[i] - b[i];
            ap[i] = p[i] - a[i];
            bp[i] = p[i] - b[i];
            cp[i] = p[i] - c[i];
        end
        d1 = dot3(ab[0], ab[1], ab[2], ap[0], ap[1], ap[2]);
        d2 = dot3(ac[0], ac[1], ac[2], ap[0], ap[1], ap[2]);
        d3 = dot3(ab[0], ab[1], ab[2], bp[0], bp[1], bp[2]);
        d4 = dot3(ac[0], ac[1], ac[2], bp[0], bp[1], bp[2]);
        d5 = dot3(ab[0], ab[1], ab[2], cp[0], cp[1], cp[2]);
        d6 = dot3(ac[0], ac[1], ac[2], cp[0], cp[1], cp[2]);
        vc = d1 * d4 - d3 * d2;
        vb = d5 * d2 - d1 * d6;
        va = d3 * d6 - d5 * d4;
        e43 = d4 - d3;
        e56 = d5 - d6;
        base = a; u = ab; v = ac; nu = 0; nv = 0; den = 1;
        if (d1 <= 0 && d2 <= 0) begin
            reg_code = cptri_pkg::REGION_VERT_A;
        end else if (d3 >= 0 && d4 - d3 <= 0) begin
            reg_code = cptri_pkg::REGION_VERT_B; base = b;
        end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
            reg_code = cptri_pkg::REGION_EDGE_AB; nu = d1; den = d1 - d3;
        end else if (d6 >= 0 && d5 - d6 <= 0) begin
            reg_code = cptri_pkg::REGION_VERT_C; base = c;
        end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
            reg_code = cptri_pkg::REGION_EDGE_AC; nv = d2; den = d2 - d6;
        end else if (va <= 0 && e43 >= 0 && e56 >= 0) begin
            reg_code = cptri_pkg::REGION_EDGE_BC;
            base = b; u = bc; nu = e43; den = e43 + e56;
        end else begin
            reg_code = cptri_pkg::REGION_FACE; nu = vb; nv = vc; den = va + vb + vc;
        end
        for (int i = 0; i < 3; i++)
            r[i] = base[i] + div_round(u[i] * nu + v[i] * nv, den);
        res.x = sat_coord(r[0]);
        res.y = sat_coord(r[1]);
        res.z = sat_coord(r[2]);
        res.region = reg_code;
        return res;
    endfunction

    // predict on input transfers, compare on output transfers
    always @(posedge aclk) begin
        point_res_t got, want;
        if (!aresetn) begin
            err_count <= 0;
            pending   <= 0;
        end else begin
            if (s_tvalid && s_tready)
                closest_q.push_back(closest_point(s_tdata));
            if (m_tvalid && m_tready) begin
                got = m_tdata[cptri_pkg::M_FIELD_W-1:0];
                if (closest_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $realtime, got);
                    err_count <= err_count + 1;
                end else begin
                    want = closest_q.pop_front();
                    if (got.x !== want.x)
                        $display("%0t: closest_x exp %0d got %0d", $realtime, want.x, got.x);
                    if (got.y !== want.y)
                        $display("%0t: closest_y exp %0d got %0d", $realtime, want.y, got.y);
                    if (got.z !== want.z)
                        $display("%0t: closest_z exp %0d got %0d", $realtime, want.z, got.z);
                    if (got.region !== want.region)
                        $display("%0t: region exp %0d got %0d", $realtime,
                                 want.region, got.region);
                    if (got !== want)
                        err_count <= err_count + 1;
                end
            end
            pending <= closest_q.size();
        end
    end

endmodule

>>> tb/tb_top.sv
// Testbench top: stimulus, output stalls, watchdog and verdict for the closest-point core.
`timescale 1ns / 1ps

module tb_top;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int ONE = 1 << 16;
    localparam int CW = cptri_pkg::COORD_W;
    localparam int SW = cptri_pkg::S_TDATA_W;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic [SW-1:0]                    s_tdata = '0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [cptri_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    int                               err_count;
    int                               pending;
    int                               idle_cycles = 0;
    int                               stall_left = 0;
    int                               stall_max = 11;
    int                               gap_max = 11;

    always #1 aclk = ~aclk;

    closest_point_on_triangle_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready)
    );

    cptri_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .err_count(err_count), .pending(pending)
    );

    // receiver stalls: a fresh wait drawn after every output transfer
    always @(posedge aclk) begin
        int draw;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                draw = $urandom_range(stall_max, 0);
                stall_left <= draw;
                m_tready <= (draw == 0);
            end else if (stall_left > 1) begin
                stall_left <= stall_left - 1;
            end else begin
                stall_left <= 0;
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[closest_point_on_triangle_core] ERROR");
            $finish;
        end
    end

    function automatic logic [SW-1:0] pack_item(input int p[3], a[3], b[3], c[3]);
        logic [SW-1:0] item;
        for (int i = 0; i < 3; i++) begin
            item[CW*i +: CW]     = p[i];
            item[CW*(3+i) +: CW] = a[i];
            item[CW*(6+i) +: CW] = b[i];
            item[CW*(9+i) +: CW] = c[i];
        end
        return item;
    endfunction

    task automatic send_query(input logic [SW-1:0] item);
        int gap;
        gap = $urandom_range(gap_max, 0);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= item;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_tri(input int px, py, pz, ax, ay, az, bx, by, bz, cx, cy, cz);
        int p[3], a[3], b[3], c[3];
        p = '{px, py, pz}; a = '{ax, ay, az}; b = '{bx, by, bz}; c = '{cx, cy, cz};
        send_query(pack_item(p, a, b, c));
    endtask

    // random coordinate: small, mid-range or full 32 bits
    function automatic int rand_coord(input int mode);
        case (mode)
            0: return $signed($urandom_range(8 * ONE, 0)) - 4 * ONE;
            1: return $signed($urandom_range(32'h7fff_ffff, 0)) - 32'sh4000_0000;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int p[3], a[3], b[3], c[3];
        int mode;
        logic [SW-1:0] item;
        int wait_cnt;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: each region of a unit right triangle in the z=0 plane
        send_tri(-ONE, -ONE, ONE,  0, 0, 0,  ONE, 0, 0,  0, ONE, 0);          // vertex a
        send_tri(2*ONE, -ONE, 0,   0, 0, 0,  ONE, 0, 0,  0, ONE, 0);          // vertex b
        send_tri(ONE/3, -ONE, 5,   0, 0, 0,  ONE, 0, 0,  0, ONE, 0);          // edge ab
        send_tri(-ONE, 2*ONE, 0,   0, 0, 0,  ONE, 0, 0,  0, ONE, 0);          // vertex c
        send_tri(-ONE, ONE/3, -7,  0, 0, 0,  ONE, 0, 0,  0, ONE, 0);          // edge ac
        send_tri(ONE, ONE, ONE,    0, 0, 0,  ONE, 0, 0,  0, ONE, 0);          // edge bc
        send_tri(ONE/4, ONE/4, ONE, 0, 0, 0, ONE, 0, 0,  0, ONE, 0);          // face
        send_tri(ONE/3, ONE/3, 3,  0, 0, 0,  ONE, 0, 0,  0, ONE, 0);          // face, rounding
        // ties on region boundaries
        send_tri(0, 0, 0,          0, 0, 0,  ONE, 0, 0,  0, ONE, 0);
        send_tri(ONE, 0, 0,        0, 0, 0,  ONE, 0, 0,  0, ONE, 0);
        send_tri(ONE/2, ONE/2, 0,  0, 0, 0,  ONE, 0, 0,  0, ONE, 0);
        // degenerate: coincident and collinear vertices
        send_tri(ONE, 2*ONE, 3*ONE,  5, 5, 5,  5, 5, 5,  5, 5, 5);
        send_tri(ONE, ONE, 0,      0, 0, 0,  ONE, 0, 0,  2*ONE, 0, 0);
        send_tri(ONE, 3*ONE, 0,    0, 0, 0,  ONE, ONE, 0,  2*ONE, 2*ONE, 0);
        // field extremes and saturation
        send_tri(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                 32'h80000000, 32'h80000000, 32'h80000000,
                 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                 32'h80000000, 32'h7fffffff, 32'h80000000);
        send_tri(32'h80000000, 32'h80000000, 32'h80000000,
                 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                 32'h80000000, 32'h7fffffff, 32'h80000000,
                 32'h7fffffff, 32'h80000000, 32'h7fffffff);
        send_tri(0, 0, 32'h7fffffff,  32'h80000000, 32'h80000000, 0,
                 32'h7fffffff, 32'h80000000, 0,  32'h80000000, 32'h7fffffff, 0);
        send_tri(-1, -1, -1,  -1, -1, -1,  -1, -1, -1,  -1, -1, -1);
        send_tri(0, 0, 0,  0, 0, 0,  0, 0, 0,  0, 0, 0);

        // random: mostly well-sized triangles, some full-range noise
        for (int n = 0; n < 1200; n++) begin
            if (n % 100 == 0) begin
                gap_max = ($urandom_range(3, 0) == 0) ? 0 : 11;
                stall_max = ($urandom_range(3, 0) == 0) ? 0 : 11;
            end
            mode = $urandom_range(9, 0);
            mode = (mode < 5) ? 0 : (mode < 8) ? 1 : 2;
            for (int i = 0; i < 3; i++) begin
                a[i] = rand_coord(mode);
                b[i] = rand_coord(mode);
                c[i] = rand_coord(mode);
                p[i] = rand_coord(mode);
            end
            // occasionally force shared vertices
            if ($urandom_range(19, 0) == 0) b = a;
            if ($urandom_range(19, 0) == 0) c = b;
            item = pack_item(p, a, b, c);
            send_query(item);
        end
        s_tvalid <= 1'b0;
        stall_max = 11;

        // drain, then let the pipe settle
        while (pending != 0) @(posedge aclk);
        wait_cnt = 0;
        while (wait_cnt < cptri_pkg::TOTAL_LAT + 20) begin
            @(posedge aclk);
            wait_cnt++;
        end
        if (err_count == 0 && pending == 0)
            $display("[closest_point_on_triangle_core] OK");
        else
            $display("[closest_point_on_triangle_core] ERROR");
        $finish;
    end

endmodule

>>> files.f
src/cptri_pkg.sv
src/cptri_mul.sv
src/cptri_div.sv
src/closest_point_on_triangle_core.sv
tb/cptri_checker.sv
tb/tb_top.sv
